/* hdl/bqlpf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers of the biquad low-pass filter.
package bqlpf_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CHAN_W       = $clog2(MAX_CHANNELS);
	localparam int SAMPLE_W     = 24;
	localparam int COEF_W       = 24;
	localparam int STATE_W      = 32;
	localparam int COUNT_W      = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int PROD_W       = COEF_W + STATE_W;
	localparam int DIFF_W       = PROD_W + 1;
	localparam int RND_W        = DIFF_W - 22;
	localparam int SUM_W        = 36;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE   = 3'd0,
		REG_CH_COUNT = 3'd1,
		REG_COEF_B0  = 3'd2,
		REG_COEF_B1  = 3'd3,
		REG_COEF_B2  = 3'd4,
		REG_COEF_A1  = 3'd5,
		REG_COEF_A2  = 3'd6
	} cfg_reg_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_M0   = 8'b0000_0010,
		ST_M1   = 8'b0000_0100,
		ST_M2   = 8'b0000_1000,
		ST_M3   = 8'b0001_0000,
		ST_M4   = 8'b0010_0000,
		ST_M5   = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} seq_state_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
		logic hi_same;
		logic lo_same;
		begin
			hi_same = &v[SUM_W-1:STATE_W-1];
			lo_same = ~|v[SUM_W-1:STATE_W-1];
			if (hi_same || lo_same) begin
				sat_state = v[STATE_W-1:0];
			end else begin
				sat_state = {v[SUM_W-1], {(STATE_W-1){~v[SUM_W-1]}}};
			end
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [STATE_W-1:0] v);
		logic hi_same;
		logic lo_same;
		begin
			hi_same = &v[STATE_W-1:SAMPLE_W-1];
			lo_same = ~|v[STATE_W-1:SAMPLE_W-1];
			if (hi_same || lo_same) begin
				sat_sample = v[SAMPLE_W-1:0];
			end else begin
				sat_sample = {v[STATE_W-1], {(SAMPLE_W-1){~v[STATE_W-1]}}};
			end
		end
	endfunction

endpackage

/* hdl/biquad_low_pass_filter.sv */
`timescale 1ns / 1ps
// Top level of the multi-channel biquad low-pass filter with one shared multiplier.
//
// Channel   Direction  Handshake                    Content
// s_axis    in         s_axis_tvalid/s_axis_tready  sample, channel in tuser, tlast
// m_axis    out        m_axis_tvalid/m_axis_tready  filtered sample, channel, tlast
// cfg       in         cfg_valid/cfg_ready          register index and write data
//
// A filtered request runs through states M0 to M5, in which the five products run one after
// another through the single 24 x 32 multiplier, and then ST_OUT loads the output register.
// A pass-through request goes from idle straight to ST_OUT. The input is ready again in the
// cycle after the load; it is not ready until the previous result has moved into the output
// register, which waits for m_axis_tready while it still holds an unaccepted result.
// Reset clears the configuration to its defaults and all channel state to zero.
module biquad_low_pass_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] sample_in
	input  logic [2:0]  s_axis_tuser,  // [2:0] chan_in
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [23:0] sample_out
	output logic [2:0]  m_axis_tuser,  // [2:0] chan_out
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	bqlpf_pkg::seq_state_t state_q;
	logic                                     enable_q;
	logic [bqlpf_pkg::COUNT_W-1:0]            ch_count_q;
	logic signed [bqlpf_pkg::COEF_W-1:0]      b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [bqlpf_pkg::STATE_W-1:0]     delay_one_q [bqlpf_pkg::MAX_CHANNELS];
	logic signed [bqlpf_pkg::STATE_W-1:0]     delay_two_q [bqlpf_pkg::MAX_CHANNELS];

	logic signed [bqlpf_pkg::SAMPLE_W-1:0]    x_q;
	logic signed [bqlpf_pkg::SAMPLE_W-1:0]    res_q;
	logic [bqlpf_pkg::CHAN_W-1:0]             ch_q;
	logic                                     last_q;
	logic signed [bqlpf_pkg::STATE_W-1:0]     s1_q, s2_q, y_q;
	logic signed [bqlpf_pkg::PROD_W-1:0]      prod_q, acc_q;

	logic                                     m_valid_q;
	logic [bqlpf_pkg::SAMPLE_W-1:0]           m_data_q;
	logic [bqlpf_pkg::CHAN_W-1:0]             m_chan_q;
	logic                                     m_last_q;

	logic                                     in_acc;
	logic                                     cfg_wr;
	logic                                     coef_wr;
	logic                                     active;
	logic                                     out_load;
	logic signed [bqlpf_pkg::COEF_W-1:0]      mul_a;
	logic signed [bqlpf_pkg::STATE_W-1:0]     mul_b;
	logic signed [bqlpf_pkg::DIFF_W-1:0]      rnd_in;
	logic signed [bqlpf_pkg::DIFF_W-1:0]      rnd_tmp;
	logic signed [bqlpf_pkg::DIFF_W-1:0]      rnd_shift;
	logic signed [bqlpf_pkg::STATE_W-1:0]     add_in;
	logic signed [bqlpf_pkg::SUM_W-1:0]       sum;
	logic signed [bqlpf_pkg::STATE_W-1:0]     sum_sat;
	logic signed [bqlpf_pkg::STATE_W-1:0]     x_ext;

	assign s_axis_tready = (state_q == bqlpf_pkg::ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_wr        = cfg_valid && cfg_ready;
	assign coef_wr       = cfg_wr && (cfg_index == bqlpf_pkg::REG_COEF_B0
		|| cfg_index == bqlpf_pkg::REG_COEF_B1 || cfg_index == bqlpf_pkg::REG_COEF_B2
		|| cfg_index == bqlpf_pkg::REG_COEF_A1 || cfg_index == bqlpf_pkg::REG_COEF_A2);
	assign active        = enable_q
		&& ({1'b0, s_axis_tuser} < ch_count_q)
		&& (32'(s_axis_tuser) < 32'(bqlpf_pkg::MAX_CHANNELS));
	assign out_load      = (state_q == bqlpf_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);
	assign x_ext         = {{(bqlpf_pkg::STATE_W-bqlpf_pkg::SAMPLE_W){x_q[bqlpf_pkg::SAMPLE_W-1]}}, x_q};

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_chan_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		mul_a = b0_q;
		mul_b = x_ext;
		unique case (state_q)
			bqlpf_pkg::ST_M0: begin
				mul_a = b0_q;
				mul_b = x_ext;
			end
			bqlpf_pkg::ST_M1: begin
				mul_a = b1_q;
				mul_b = x_ext;
			end
			bqlpf_pkg::ST_M2: begin
				mul_a = a1_q;
				mul_b = y_q;
			end
			bqlpf_pkg::ST_M3: begin
				mul_a = b2_q;
				mul_b = x_ext;
			end
			bqlpf_pkg::ST_M4: begin
				mul_a = a2_q;
				mul_b = y_q;
			end
			default: begin
				mul_a = b0_q;
				mul_b = x_ext;
			end
		endcase
	end

	// Shared rounding, accumulate and saturation path.
	always_comb begin
		if (state_q == bqlpf_pkg::ST_M1) begin
			rnd_in = {prod_q[bqlpf_pkg::PROD_W-1], prod_q};
			add_in = s1_q;
		end else if (state_q == bqlpf_pkg::ST_M3) begin
			rnd_in = {acc_q[bqlpf_pkg::PROD_W-1], acc_q}
				- {prod_q[bqlpf_pkg::PROD_W-1], prod_q};
			add_in = s2_q;
		end else begin
			rnd_in = {acc_q[bqlpf_pkg::PROD_W-1], acc_q}
				- {prod_q[bqlpf_pkg::PROD_W-1], prod_q};
			add_in = '0;
		end
		rnd_tmp   = rnd_in + bqlpf_pkg::DIFF_W'(1 << 21);
		rnd_shift = rnd_tmp >>> 22;
		sum       = {rnd_shift[bqlpf_pkg::RND_W-1], rnd_shift[bqlpf_pkg::RND_W-1:0]}
			+ {{(bqlpf_pkg::SUM_W-bqlpf_pkg::STATE_W){add_in[bqlpf_pkg::STATE_W-1]}}, add_in};
		sum_sat   = bqlpf_pkg::sat_state(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bqlpf_pkg::ST_IDLE;
			enable_q   <= 1'b0;
			ch_count_q <= bqlpf_pkg::COUNT_W'(bqlpf_pkg::MAX_CHANNELS);
			b0_q       <= '0;
			b1_q       <= '0;
			b2_q       <= '0;
			a1_q       <= '0;
			a2_q       <= '0;
			m_valid_q  <= 1'b0;
			for (int i = 0; i < bqlpf_pkg::MAX_CHANNELS; i++) begin
				delay_one_q[i] <= '0;
				delay_two_q[i] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					bqlpf_pkg::REG_ENABLE:   enable_q   <= cfg_data[0];
					bqlpf_pkg::REG_CH_COUNT: ch_count_q <= cfg_data[bqlpf_pkg::COUNT_W-1:0];
					bqlpf_pkg::REG_COEF_B0:  b0_q       <= cfg_data;
					bqlpf_pkg::REG_COEF_B1:  b1_q       <= cfg_data;
					bqlpf_pkg::REG_COEF_B2:  b2_q       <= cfg_data;
					bqlpf_pkg::REG_COEF_A1:  a1_q       <= cfg_data;
					bqlpf_pkg::REG_COEF_A2:  a2_q       <= cfg_data;
					default: begin
					end
				endcase
			end

			if (coef_wr) begin
				for (int i = 0; i < bqlpf_pkg::MAX_CHANNELS; i++) begin
					delay_one_q[i] <= '0;
					delay_two_q[i] <= '0;
				end
			end else if (state_q == bqlpf_pkg::ST_M3) begin
				delay_one_q[ch_q] <= sum_sat;
			end else if (state_q == bqlpf_pkg::ST_M5) begin
				delay_two_q[ch_q] <= sum_sat;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				bqlpf_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= active ? bqlpf_pkg::ST_M0 : bqlpf_pkg::ST_OUT;
					end
				end
				bqlpf_pkg::ST_M0:  state_q <= bqlpf_pkg::ST_M1;
				bqlpf_pkg::ST_M1:  state_q <= bqlpf_pkg::ST_M2;
				bqlpf_pkg::ST_M2:  state_q <= bqlpf_pkg::ST_M3;
				bqlpf_pkg::ST_M3:  state_q <= bqlpf_pkg::ST_M4;
				bqlpf_pkg::ST_M4:  state_q <= bqlpf_pkg::ST_M5;
				bqlpf_pkg::ST_M5:  state_q <= bqlpf_pkg::ST_OUT;
				bqlpf_pkg::ST_OUT: begin
					if (out_load) begin
						state_q <= bqlpf_pkg::ST_IDLE;
					end
				end
				default: state_q <= bqlpf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= s_axis_tdata;
			res_q  <= s_axis_tdata;
			ch_q   <= s_axis_tuser;
			last_q <= s_axis_tlast;
			s1_q   <= delay_one_q[s_axis_tuser];
			s2_q   <= delay_two_q[s_axis_tuser];
		end
		prod_q <= mul_a * mul_b;
		if (state_q == bqlpf_pkg::ST_M1) begin
			y_q   <= sum_sat;
			res_q <= bqlpf_pkg::sat_sample(sum_sat);
		end
		if (state_q == bqlpf_pkg::ST_M2 || state_q == bqlpf_pkg::ST_M4) begin
			acc_q <= prod_q;
		end
		if (out_load) begin
			m_data_q <= res_q;
			m_chan_q <= ch_q;
			m_last_q <= last_q;
		end
	end

endmodule

/* test/biquad_low_pass_filter_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the biquad low-pass filter: a directed table, then random phases.
module biquad_low_pass_filter_test;

	localparam int          CLK_PERIOD   = 20;
	localparam int          RANDOM_ITEMS = 650;
	localparam int          STALL_LIMIT  = 5000;
	localparam int          LONG_HOLD    = 400;
	localparam int          SETTLE       = 12;
	localparam logic [2:0]  REG_SPARE    = 3'd7;

	localparam logic signed [23:0] LP_B0 = 24'sd283000;
	localparam logic signed [23:0] LP_B1 = 24'sd566000;
	localparam logic signed [23:0] LP_B2 = 24'sd283000;
	localparam logic signed [23:0] LP_A1 = -24'sd4794000;
	localparam logic signed [23:0] LP_A2 = 24'sd1731000;

	typedef struct packed {
		logic [23:0] sample;
		logic [2:0]  chan;
		logic        last;
	} filt_result_t;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_idx;
		logic [23:0] value;
		logic [2:0]  chan;
		logic        last;
		logic        typed;
		logic [23:0] typed_out;
	} stim_row_t;

	localparam int N_ROWS = 33;

	// Register rows carry the write data in the value column; item rows carry the sample.
	stim_row_t directed [N_ROWS] = '{
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b0, 1'b1, 24'h7FFFFF},
		'{ROW_ITEM,  REG_SPARE,              24'h800000, 3'd7, 1'b1, 1'b1, 24'h800000},
		'{ROW_ITEM,  REG_SPARE,              24'h000000, 3'd3, 1'b0, 1'b1, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'hA5A5A5, 3'd5, 1'b1, 1'b1, 24'hA5A5A5},
		'{ROW_WRITE, bqlpf_pkg::REG_ENABLE,   24'hFFFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd2, 1'b0, 1'b1, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_COEF_B0,  24'h400000, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b1, 1'b1, 24'h7FFFFF},
		'{ROW_ITEM,  REG_SPARE,              24'h800000, 3'd1, 1'b0, 1'b1, 24'h800000},
		'{ROW_ITEM,  REG_SPARE,              24'h000001, 3'd6, 1'b0, 1'b1, 24'h000001},
		'{ROW_WRITE, bqlpf_pkg::REG_COEF_B0,  24'h7FFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_COEF_B1,  24'h7FFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_COEF_B2,  24'h7FFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_COEF_A1,  24'h800000, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_COEF_A2,  24'h800000, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b1, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h800000, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h800000, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h123456, 3'd4, 1'b1, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_CH_COUNT, 24'h000003, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h654321, 3'd3, 1'b0, 1'b1, 24'h654321},
		'{ROW_ITEM,  REG_SPARE,              24'h800000, 3'd7, 1'b1, 1'b1, 24'h800000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd2, 1'b0, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_CH_COUNT, 24'hFFFFF0, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b0, 1'b1, 24'h7FFFFF},
		'{ROW_WRITE, bqlpf_pkg::REG_CH_COUNT, 24'h00000F, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd7, 1'b0, 1'b0, 24'h000000},
		'{ROW_WRITE, REG_SPARE,              24'hFFFFFF, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h800000, 3'd7, 1'b1, 1'b0, 24'h000000},
		'{ROW_WRITE, bqlpf_pkg::REG_ENABLE,   24'hFFFFFE, 3'd0, 1'b0, 1'b0, 24'h000000},
		'{ROW_ITEM,  REG_SPARE,              24'h7FFFFF, 3'd0, 1'b1, 1'b1, 24'h7FFFFF}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	filt_result_t pending_out [$];
	int unsigned  error_count    = 0;
	int unsigned  items_accepted = 0;
	int unsigned  burst_left     = 0;

	// Predictor copy of the configuration and of the per-channel accumulators.
	logic                                 filt_en;
	logic [3:0]                           filt_chans;
	logic signed [23:0]                   c_b0, c_b1, c_b2, c_a1, c_a2;
	logic signed [bqlpf_pkg::STATE_W-1:0] acc_one [bqlpf_pkg::MAX_CHANNELS];
	logic signed [bqlpf_pkg::STATE_W-1:0] acc_two [bqlpf_pkg::MAX_CHANNELS];

	biquad_low_pass_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint round_q22(input longint v);
		return (v + (64'sd1 <<< 21)) >>> 22;
	endfunction

	function automatic void clear_accumulators();
		for (int i = 0; i < bqlpf_pkg::MAX_CHANNELS; i++) begin
			acc_one[i] = '0;
			acc_two[i] = '0;
		end
	endfunction

	function automatic void apply_register(input logic [2:0] idx, input logic [23:0] data);
		case (idx)
			bqlpf_pkg::REG_ENABLE: begin
				filt_en = data[0];
			end
			bqlpf_pkg::REG_CH_COUNT: begin
				filt_chans = data[3:0];
			end
			bqlpf_pkg::REG_COEF_B0: begin
				c_b0 = data;
				clear_accumulators();
			end
			bqlpf_pkg::REG_COEF_B1: begin
				c_b1 = data;
				clear_accumulators();
			end
			bqlpf_pkg::REG_COEF_B2: begin
				c_b2 = data;
				clear_accumulators();
			end
			bqlpf_pkg::REG_COEF_A1: begin
				c_a1 = data;
				clear_accumulators();
			end
			bqlpf_pkg::REG_COEF_A2: begin
				c_a2 = data;
				clear_accumulators();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [23:0] filter_sample(input logic signed [23:0] x, input logic [2:0] ch);
		longint y;
		longint n1;
		longint n2;
		if (!filt_en || ch >= filt_chans || int'(ch) >= bqlpf_pkg::MAX_CHANNELS) begin
			return x;
		end
		y  = clamp(round_q22(longint'(c_b0) * longint'(x)) + longint'(acc_one[ch]),
			-64'sd2147483648, 64'sd2147483647);
		n1 = clamp(round_q22(longint'(c_b1) * longint'(x) - longint'(c_a1) * y)
			+ longint'(acc_two[ch]), -64'sd2147483648, 64'sd2147483647);
		n2 = clamp(round_q22(longint'(c_b2) * longint'(x) - longint'(c_a2) * y),
			-64'sd2147483648, 64'sd2147483647);
		acc_one[ch] = n1[bqlpf_pkg::STATE_W-1:0];
		acc_two[ch] = n2[bqlpf_pkg::STATE_W-1:0];
		return 24'(clamp(y, -64'sd8388608, 64'sd8388607));
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] want,
		input logic [23:0] got);
		$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
		error_count++;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [23:0] data);
		s_axis_tvalid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, data);
	endtask

	task automatic send_sample(input logic [23:0] x, input logic [2:0] ch, input logic last,
		input logic typed, input logic [23:0] typed_out);
		logic [23:0] predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		s_axis_tuser  <= ch;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		predicted = filter_sample(x, ch);
		pending_out.push_back('{typed ? typed_out : predicted, ch, last});
		items_accepted++;
	endtask

	// The sender offers requests in bursts; between bursts it may drop tvalid for a random gap.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return 24'(int'($urandom_range(0, 8191)) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] pick_coef(input int unsigned mode);
		if (mode == 2) begin
			return 24'($urandom);
		end
		return 24'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
	endfunction

	initial begin : stimulus
		logic [23:0] data;
		int unsigned mode;
		int unsigned phase_len;
		int unsigned random_items;
		int unsigned rr_chan;
		int unsigned active;
		logic [2:0]  ch;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= bqlpf_pkg::REG_ENABLE;
		cfg_data      <= '0;
		filt_en    = 1'b0;
		filt_chans = 4'd8;
		c_b0 = '0;
		c_b1 = '0;
		c_b2 = '0;
		c_a1 = '0;
		c_a2 = '0;
		clear_accumulators();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				write_register(directed[i].reg_idx, directed[i].value);
			end else begin
				send_sample(directed[i].value, directed[i].chan, directed[i].last,
					directed[i].typed, directed[i].typed_out);
				pace_sender();
			end
		end

		random_items = 0;
		rr_chan = 0;
		while (random_items < RANDOM_ITEMS) begin
			data = 24'($urandom);
			data[0] = ($urandom_range(0, 6) != 0);
			write_register(bqlpf_pkg::REG_ENABLE, data);
			data = 24'($urandom);
			data[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 8));
			write_register(bqlpf_pkg::REG_CH_COUNT, data);
			mode = $urandom_range(0, 3);
			if (mode == 1) begin
				write_register(bqlpf_pkg::REG_COEF_B0, LP_B0);
				write_register(bqlpf_pkg::REG_COEF_B1, LP_B1);
				write_register(bqlpf_pkg::REG_COEF_B2, LP_B2);
				write_register(bqlpf_pkg::REG_COEF_A1, LP_A1);
				write_register(bqlpf_pkg::REG_COEF_A2, LP_A2);
			end else if (mode != 0) begin
				write_register(bqlpf_pkg::REG_COEF_B0, pick_coef(mode));
				write_register(bqlpf_pkg::REG_COEF_B1, pick_coef(mode));
				write_register(bqlpf_pkg::REG_COEF_B2, pick_coef(mode));
				write_register(bqlpf_pkg::REG_COEF_A1, pick_coef(mode));
				write_register(bqlpf_pkg::REG_COEF_A2, pick_coef(mode));
			end
			if ($urandom_range(0, 5) == 0) begin
				write_register(REG_SPARE, 24'($urandom));
			end
			active = (filt_chans == 0 || filt_chans > bqlpf_pkg::MAX_CHANNELS)
				? bqlpf_pkg::MAX_CHANNELS : filt_chans;
			phase_len = $urandom_range(40, 110);
			for (int n = 0; n < phase_len && random_items < RANDOM_ITEMS; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					ch = 3'(rr_chan % active);
					rr_chan++;
				end else begin
					ch = 3'($urandom_range(0, 7));
				end
				send_sample(pick_sample(), ch, ($urandom_range(0, 7) == 0), 1'b0, '0);
				random_items++;
				pace_sender();
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// The receiver runs its own stall pattern and, once, a long hold-off that backs up the input.
	initial begin : sink_pacing
		int unsigned on_len;
		int unsigned off_len;
		bit          held;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && items_accepted >= 200) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				held = 1'b1;
			end
			on_len = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 25);
			m_axis_tready <= 1'b1;
			repeat (on_len) @(posedge clk);
			off_len = $urandom_range(0, 7);
			if (off_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_output
		filt_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_out.size() == 0) begin
				report_mismatch("unexpected result", '0, m_axis_tdata);
			end else begin
				want = pending_out.pop_front();
				if (m_axis_tdata !== want.sample) begin
					report_mismatch("sample_out", want.sample, m_axis_tdata);
				end
				if (m_axis_tuser !== want.chan) begin
					report_mismatch("chan_out", 24'(want.chan), 24'(m_axis_tuser));
				end
				if (m_axis_tlast !== want.last) begin
					report_mismatch("last_out", 24'(want.last), 24'(m_axis_tlast));
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* biquad_low_pass_filter.f */
hdl/bqlpf_pkg.sv
hdl/biquad_low_pass_filter.sv
test/biquad_low_pass_filter_test.sv
